[rtl/skset_pkg.sv]
// shared types and codes for the sorted key set unit
// no dependencies; compiled first

package skset_pkg;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        status_t                  status;
        logic signed [KEY_W-1:0]  key;
        logic                     last;
    } result_t;

endpackage

[rtl/skset_req_if.sv]
// request channel: command and key with valid / ready
// no dependencies

interface skset_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

[rtl/skset_rsp_if.sv]
// response channel: status, key and last flag with valid / ready
// no dependencies

interface skset_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic               last;

    modport source (output valid, output status, output out_key, output last, input ready);
    modport sink   (input valid, input status, input out_key, input last, output ready);
endinterface

[rtl/sorted_key_set_insert_delete_unit.sv]
// top level of the sorted key set: sequencer, key storage, response register
// depends on skset_pkg, skset_req_if, skset_rsp_if, skset_mem, skset_ctrl
//
//   channel   dir   signals                       meaning
//   req       in    valid ready cmd key           insert / delete / dump request
//   rsp       out   valid ready status out_key    one result; last marks the final one
//                   last
//
// delete accepts the request, walks every stored key through the single memory read port
// and comparator, then posts the result; insert does the same, but a duplicate or a full
// set stops the walk at the first key not below it
// dump posts one stored key per result, or the empty marker when the set is empty
// rst_n clears the key count and sequencer; stored keys keep whatever they held
// a stalled rsp holds a dump and the final result post; req is ready only while the sequencer idles,
// also while the last result still waits in the response register

module sorted_key_set_insert_delete_unit #(
    parameter int CAPACITY = 16
) (
    input logic         clk,
    input logic         rst_n,
    skset_req_if.sink   req,
    skset_rsp_if.source rsp
);

    import skset_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // memory port wiring
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // result hand-off from the sequencer
    logic    emit;
    logic    out_free;
    result_t result;

    // response register
    logic    rsp_valid_reg, rsp_valid_next;
    result_t rsp_data_reg, rsp_data_next;

    skset_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    skset_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_cmd   (req.cmd),
        .req_key   (req.key),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_free  (out_free),
        .emit      (emit),
        .result    (result)
    );

    // slot is free when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        priority if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = result;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_data_reg.status;
    assign rsp.out_key = rsp_data_reg.key;
    assign rsp.last    = rsp_data_reg.last;

endmodule

[rtl/skset_mem.sv]
// key storage: one write port, one read port with registered read data
// no package dependencies

module skset_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while the sequencer is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/skset_ctrl.sv]
// sequencer and shared key comparator for insert, delete and dump
// depends on skset_pkg; drives skset_mem ports

module skset_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [1:0]               req_cmd,
    input  logic signed [31:0]       req_key,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  logic [31:0]              rd_data,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [31:0]              wr_data,
    input  logic                     out_free,
    output logic                     emit,
    output skset_pkg::result_t       result
);

    import skset_pkg::*;

    state_t             state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic signed [31:0] key_reg, key_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               carry_reg, carry_next;
    logic [31:0]        hold_reg, hold_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;

    logic full;
    logic is_last;
    logic lt;
    logic eq;
    logic scan_stop;

    // the shared compare unit
    assign lt      = $signed(rd_data) < key_reg;
    assign eq      = rd_data == key_reg;
    assign full    = count_reg == CW'(CAPACITY);
    assign is_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        carry_reg  <= carry_next;
        hold_reg   <= hold_next;
        done_reg   <= done_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && (req_cmd == CMD_INSERT || req_cmd == CMD_DELETE
                                  || req_cmd == CMD_DUMP))
                begin
                    state_next = (count_reg == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmd_reg == CMD_DUMP)
                begin
                    if (out_free && is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (scan_stop)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = AW'(idx_reg + AW'(1));
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = key_reg;
        emit        = 1'b0;
        result      = '{status: ST_OK, key: key_reg, last: 1'b1};
        scan_stop   = 1'b0;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        carry_next  = carry_reg;
        hold_next   = hold_reg;
        done_next   = done_reg;
        status_next = status_reg;
        count_next  = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next    = req_cmd;
                    key_next    = req_key;
                    idx_next    = '0;
                    carry_next  = 1'b0;
                    done_next   = 1'b0;
                    status_next = ST_OK;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                end
            end

            S_SCAN:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        // carry ripples every entry above the slot up by one
                        if (!carry_reg)
                        begin
                            priority if (lt)
                            begin
                            end
                            else if (eq)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_DUP;
                            end
                            else if (full)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = key_reg;
                                carry_next = 1'b1;
                                hold_next  = rd_data;
                            end
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_data   = hold_reg;
                            hold_next = rd_data;
                        end
                        scan_stop = done_next || is_last;
                        if (!scan_stop)
                        begin
                            rd_en    = 1'b1;
                            idx_next = AW'(idx_reg + AW'(1));
                        end
                    end
                    CMD_DELETE:
                    begin
                        // after the match every entry moves down one slot
                        if (!carry_reg)
                        begin
                            if (eq)
                            begin
                                carry_next = 1'b1;
                            end
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(idx_reg - AW'(1));
                            wr_data = rd_data;
                        end
                        scan_stop = is_last;
                        if (!scan_stop)
                        begin
                            rd_en    = 1'b1;
                            idx_next = AW'(idx_reg + AW'(1));
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (out_free)
                        begin
                            emit   = 1'b1;
                            result = '{status: ST_OK, key: $signed(rd_data), last: is_last};
                            if (!is_last)
                            begin
                                rd_en    = 1'b1;
                                idx_next = AW'(idx_reg + AW'(1));
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            priority if (done_reg)
                            begin
                                result.status = status_reg;
                            end
                            else if (carry_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = hold_reg;
                                count_next = CW'(count_reg + CW'(1));
                            end
                            else if (full)
                            begin
                                result.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = key_reg;
                                count_next = CW'(count_reg + CW'(1));
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (carry_reg)
                            begin
                                count_next = CW'(count_reg - CW'(1));
                            end
                            else
                            begin
                                result.status = ST_NOTFOUND;
                            end
                        end
                        CMD_DUMP:
                        begin
                            result = '{status: ST_EMPTY, key: '0, last: 1'b1};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            default:
            begin
            end
        endcase
    end

endmodule

[sim/sorted_key_set_insert_delete_unit_test.sv]
`timescale 1ns / 1ps
// self-checking bench for sorted_key_set_insert_delete_unit: predicts every result
// from its own copy of the key set; needs skset_pkg, skset_req_if, skset_rsp_if and the rtl

module sorted_key_set_insert_delete_unit_test;

    import skset_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int IDLE_LIMIT       = 4000;
    localparam int HOLD_CYCLES      = 300;
    // worst case for one request: a full walk, a full dump, margin
    localparam int SETTLE_CYCLES    = 2 * CAPACITY + 8;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;

    skset_req_if req_ch ();
    skset_rsp_if rsp_ch ();

    sorted_key_set_insert_delete_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted contents of the set, ascending in entries 0 .. set_count-1
    logic signed [KEY_W-1:0] set_keys [CAPACITY];
    int unsigned             set_count;
    result_t                 awaited_results [$];

    // idling controls shared between the test tasks and the two channel sides
    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned rx_stall_left;
    int unsigned hold_left;

    // bookkeeping for the summary
    int unsigned error_count;
    int unsigned results_checked;
    int unsigned n_insert;
    int unsigned n_delete;
    int unsigned n_dump;
    int unsigned n_unused;
    int unsigned n_full;
    int unsigned n_dup;
    int unsigned n_notfound;
    int unsigned peak_count;

    function automatic void await_result(status_t status, logic signed [KEY_W-1:0] key,
                                         logic last);
        result_t r;
        r.status = status;
        r.key    = key;
        r.last   = last;
        awaited_results.push_back(r);
    endfunction

    // update the predicted set for one accepted request and queue what it must return
    function automatic void predict_request(logic [CMD_W-1:0] op,
                                            logic signed [KEY_W-1:0] key);
        int unsigned pos;
        int unsigned j;
        case (op)
            CMD_INSERT:
            begin
                n_insert++;
                // first entry not below the key
                pos = 0;
                while (pos < set_count && set_keys[pos] < key)
                    pos++;
                if (pos < set_count && set_keys[pos] == key)
                begin
                    // duplicate wins over full
                    n_dup++;
                    await_result(ST_DUP, key, 1'b1);
                end
                else if (set_count >= CAPACITY)
                begin
                    n_full++;
                    await_result(ST_FULL, key, 1'b1);
                end
                else
                begin
                    for (j = set_count; j > pos; j--)
                        set_keys[j] = set_keys[j-1];
                    set_keys[pos] = key;
                    set_count++;
                    if (set_count > peak_count)
                        peak_count = set_count;
                    await_result(ST_OK, key, 1'b1);
                end
            end
            CMD_DELETE:
            begin
                n_delete++;
                pos = 0;
                while (pos < set_count && set_keys[pos] != key)
                    pos++;
                if (pos >= set_count)
                begin
                    n_notfound++;
                    await_result(ST_NOTFOUND, key, 1'b1);
                end
                else
                begin
                    for (j = pos; j + 1 < set_count; j++)
                        set_keys[j] = set_keys[j+1];
                    set_count--;
                    await_result(ST_OK, key, 1'b1);
                end
            end
            CMD_DUMP:
            begin
                n_dump++;
                if (set_count == 0)
                    await_result(ST_EMPTY, '0, 1'b1);
                else
                    for (j = 0; j < set_count; j++)
                        await_result(ST_OK, set_keys[j], j + 1 == set_count);
            end
            default:
                // unused code: no state change, no result
                n_unused++;
        endcase
    endfunction

    function automatic void check_field(string field, logic signed [KEY_W:0] want,
                                        logic signed [KEY_W:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // compare one accepted result against the oldest prediction
    function automatic void check_result();
        result_t want;
        results_checked++;
        if (awaited_results.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual status %0d key %0d last %0d",
                     $time, rsp_ch.status, rsp_ch.out_key, rsp_ch.last);
            return;
        end
        want = awaited_results.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("out_key", want.key, rsp_ch.out_key);
        check_field("last", want.last, rsp_ch.last);
    endfunction

    // one request: optional random gap, then hold valid until the handshake;
    // valid stays high when the next request follows without a gap
    task automatic send_request(input logic [CMD_W-1:0] op, input logic signed [KEY_W-1:0] key);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= op;
        req_ch.key   <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(op, key);
    endtask

    // key mix: stored keys, a narrow band around zero, the extremes, anything
    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && set_count != 0)
            return set_keys[$urandom_range(0, set_count - 1)];
        if (roll < 60)
            return int'($urandom_range(0, 20)) - 10;
        if (roll < 70)
        begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [CMD_W-1:0] pick_op(int unsigned insert_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            return CMD_INSERT;
        if (roll < 88)
            return CMD_DELETE;
        if (roll < 96)
            return CMD_DUMP;
        return CMD_UNUSED;
    endfunction

    // ---------------------------------------------------------------- tests

    // empty set: dump gives the empty marker, delete misses, unused code is dropped
    task automatic test_empty_set();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_request(CMD_DUMP, $urandom());
        send_request(CMD_DELETE, 32'sd5);
        send_request(CMD_UNUSED, $urandom());
        send_request(CMD_DUMP, '0);
    endtask

    // signed ordering across the extremes, duplicates, deletes at both ends
    task automatic test_key_extremes();
        send_request(CMD_INSERT, KEY_MAX);
        send_request(CMD_INSERT, 32'sd0);
        send_request(CMD_INSERT, KEY_MIN);
        send_request(CMD_INSERT, -32'sd1);
        send_request(CMD_INSERT, 32'sd1);
        send_request(CMD_INSERT, KEY_MIN);
        send_request(CMD_INSERT, KEY_MAX);
        send_request(CMD_DUMP, $urandom());
        send_request(CMD_DELETE, KEY_MAX);
        send_request(CMD_DELETE, KEY_MIN);
        send_request(CMD_DELETE, 32'sd0);
        send_request(CMD_DELETE, 32'sd0);
        send_request(CMD_UNUSED, KEY_MAX);
        send_request(CMD_DUMP, '0);
    endtask

    // random traffic, insert heavy at first so the set grows, then balanced
    task automatic test_random_mix(input int unsigned count);
        int unsigned i;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (i = 0; i < count; i++)
            send_request(pick_op(i < count / 2 ? 65 : 45), pick_key());
    endtask

    // fill to capacity, then full and duplicate-on-full rejects, then free one slot
    task automatic test_full_set();
        int unsigned guard;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        guard = 0;
        while (set_count < CAPACITY && guard < 4 * CAPACITY)
        begin
            send_request(CMD_INSERT, $urandom());
            guard++;
        end
        send_request(CMD_INSERT, $urandom());
        send_request(CMD_INSERT, set_keys[0]);
        send_request(CMD_INSERT, set_keys[CAPACITY-1]);
        send_request(CMD_INSERT, set_keys[CAPACITY/2]);
        send_request(CMD_DUMP, $urandom());
        send_request(CMD_DELETE, set_keys[CAPACITY/2]);
        send_request(CMD_INSERT, KEY_MIN);
        send_request(CMD_INSERT, KEY_MAX);
        send_request(CMD_DUMP, '0);
    endtask

    // empty the set in random order with a few misses mixed in
    task automatic test_drain();
        int unsigned guard;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        guard = 0;
        while (set_count != 0 && guard < 4 * CAPACITY)
        begin
            if ($urandom_range(0, 4) == 0)
                send_request(CMD_DELETE, $urandom());
            else
                send_request(CMD_DELETE, set_keys[$urandom_range(0, set_count - 1)]);
            guard++;
        end
        send_request(CMD_DUMP, $urandom());
        send_request(CMD_DELETE, pick_key());
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the response register fills and the request side stalls
    task automatic test_receiver_hold();
        int unsigned i;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_left  = HOLD_CYCLES;
        for (i = 0; i < 6; i++)
            send_request(CMD_INSERT, pick_key());
        send_request(CMD_DUMP, $urandom());
        send_request(CMD_UNUSED, $urandom());
        send_request(CMD_DELETE, pick_key());
        send_request(CMD_DUMP, $urandom());
    endtask

    // back to back on both sides
    task automatic test_burst(input int unsigned count);
        int unsigned i;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (i = 0; i < count; i++)
            send_request(pick_op(50), pick_key());
    endtask

    // ---------------------------------------------------------------- response side

    // checks on the edge, then decides ready for the next cycle; a long hold
    // requested by a test is counted down here
    initial
    begin : result_sink
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                check_result();
                rx_stall_left = rx_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_stall_left != 0)
            begin
                rx_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog: ends the run when neither channel moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d results still awaited", $time,
                         awaited_results.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin : main_sequence
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.cmd    <= CMD_INSERT;
        req_ch.key    <= '0;
        set_count     = 0;
        rx_stall_left = 0;
        hold_left     = 0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set();
        test_key_extremes();
        test_random_mix(45);
        test_full_set();
        test_drain();
        test_receiver_hold();
        test_burst(12);

        // last request accepted on this edge; stop offering
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        // let any stray result show up before deciding
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            error_count++;

        $display("covered %0d inserts, %0d deletes, %0d dumps, %0d unused requests; %0d results",
                 n_insert, n_delete, n_dump, n_unused, results_checked);
        $display("rejects: %0d full, %0d duplicate, %0d not found; peak fill %0d of %0d",
                 n_full, n_dup, n_notfound, peak_count, CAPACITY);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sorted_key_set_insert_delete_unit.f]
rtl/skset_pkg.sv
rtl/skset_req_if.sv
rtl/skset_rsp_if.sv
rtl/skset_mem.sv
rtl/skset_ctrl.sv
rtl/sorted_key_set_insert_delete_unit.sv
sim/sorted_key_set_insert_delete_unit_test.sv
